@@ src/etf_pkg.sv @@
`timescale 1ns / 1ps

package etf_pkg;

	parameter int MAX_ITER_DEF   = 300;
	parameter int IMG_WIDTH_DEF  = 1000;
	parameter int IMG_HEIGHT_DEF = 800;
	parameter int FRAC_BITS_DEF  = 28;

	parameter int PIX_W     = 10;
	parameter int WORD_W    = 32;
	parameter int COLOR_W   = 24;
	parameter int ITER_W    = 9;
	parameter int CFG_IDX_W = 3;
	// pixel offset from centre: -512 .. 511 at the largest image size
	parameter int OFS_W     = 13;
	parameter int PROD_W    = OFS_W + WORD_W;

	parameter logic [COLOR_W-1:0] COLOR_STEP   = 24'd16777;
	parameter logic [COLOR_W-1:0] COLOR_INSIDE = 24'hAA0000;

	parameter logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
	parameter logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd1;
	parameter logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd2;
	parameter logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd3;
	parameter logic [CFG_IDX_W-1:0] REG_JULIA_C_REAL = 3'd4;
	parameter logic [CFG_IDX_W-1:0] REG_JULIA_C_IMAG = 3'd5;

	parameter logic signed [WORD_W-1:0] SCALE_RST  = 32'sd268435456;
	parameter logic signed [WORD_W-1:0] JULIA_RE_RST = -32'sd214748365;
	parameter logic signed [WORD_W-1:0] JULIA_IM_RST = 32'sd41875931;

	typedef struct packed {
		logic load_pix;
		logic div_start;
		logic load_z;
		logic mul;
		logic step;
		logic finish;
		logic out_load;
	} etf_cmd_t;

	typedef struct packed {
		logic div_done;
		logic escape;
		logic limit;
	} etf_stat_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [71:0] v);
		if (v > 72'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -72'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[WORD_W-1:0];
		end
	endfunction

endpackage

@@ src/etf_if.sv @@
`timescale 1ns / 1ps

interface etf_pixel_if;
	import etf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface etf_result_if;
	import etf_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] color;
	logic               escaped;
	logic [ITER_W-1:0]  iterations;
	modport source (output valid, output color, output escaped, output iterations, input ready);
	modport sink (input valid, input color, input escaped, input iterations, output ready);
endinterface

@@ src/etf_div.sv @@
`timescale 1ns / 1ps

module etf_div
	import etf_pkg::*;
#(
	parameter int unsigned DIVISOR = 250,
	parameter int unsigned WIDTH   = PROD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	output logic [WIDTH-1:0] quotient,
	output logic             done
);

	// long division on 16-bit digits, each digit by reciprocal multiplication
	localparam int DIG_W = 16;
	localparam int N_DIG = (WIDTH + DIG_W - 1) / DIG_W;
	localparam int PAD_W = N_DIG * DIG_W;
	localparam int LOG_D = $clog2(DIVISOR);
	localparam int RW    = LOG_D + 1;
	localparam int XW    = DIG_W + RW;
	localparam int SH    = XW + LOG_D;
	localparam int RCP_W = XW + 2;
	localparam int PW    = XW + RCP_W;
	localparam int CNT_W = $clog2(N_DIG + 1);
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam logic [XW-1:0]    DIV_V    = XW'(DIVISOR);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(N_DIG);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [RW-1:0]    rem_q;
	logic [PAD_W-1:0] num_q;
	logic [PAD_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             phase_q;
	logic [XW-1:0]    x_s1;
	logic [DIG_W-1:0] qd_s1;
	logic [XW-1:0]    x;
	logic [PW-1:0]    prod;
	logic [XW-1:0]    back;
	logic [XW-1:0]    rem_full;

	assign x        = {rem_q, num_q[PAD_W-1 -: DIG_W]};
	assign prod     = PW'(x) * PW'(RCP);
	assign back     = XW'(qd_s1) * DIV_V;
	assign rem_full = x_s1 - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			cnt_q   <= CNT_INIT;
		end else if (busy_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				cnt_q <= cnt_q - CNT_ONE;
				if (cnt_q == CNT_ONE) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= PAD_W'(dividend);
		end else if (busy_q) begin
			if (!phase_q) begin
				x_s1  <= x;
				qd_s1 <= prod[SH +: DIG_W];
				num_q <= num_q << DIG_W;
			end else begin
				rem_q  <= rem_full[RW-1:0];
				quot_q <= (quot_q << DIG_W) | PAD_W'(qd_s1);
			end
		end
	end

	assign quotient = quot_q[WIDTH-1:0];
	assign done     = !busy_q;

endmodule

@@ src/etf_dp.sv @@
`timescale 1ns / 1ps

module etf_dp
	import etf_pkg::*;
#(
	parameter int MAX_ITER   = MAX_ITER_DEF,
	parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [WORD_W-1:0]    cfg_wdata,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	input  etf_cmd_t             cmd,
	output etf_stat_t            st,
	output logic [COLOR_W-1:0]   color,
	output logic                 escaped,
	output logic [ITER_W-1:0]    iterations
);

	localparam int DX        = (IMG_WIDTH / 4 > 0) ? IMG_WIDTH / 4 : 1;
	localparam int DY        = (IMG_HEIGHT / 4 > 0) ? IMG_HEIGHT / 4 : 1;
	localparam int CW        = $clog2(MAX_ITER + 1);
	localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam logic [CW-1:0] N_MAX = CW'(MAX_ITER);
	localparam logic [CW-1:0] N_ONE = CW'(1);
	localparam logic [OFS_W-1:0] CX = OFS_W'(2 * DX);
	localparam logic [OFS_W-1:0] CY = OFS_W'(2 * DY);

	logic                     mode_q;
	logic signed [WORD_W-1:0] scale_q, xoff_q, yoff_q, jre_q, jim_q;
	logic [PIX_W-1:0]         px_q, py_q;
	logic                     negx_q, negy_q;
	logic signed [WORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic signed [63:0]       rr_s1, ii_s1, ri_s1;
	logic [CW-1:0]            n_q;
	logic                     esc_q;
	logic [COLOR_W-1:0]       color_q;
	logic                     escaped_q;
	logic [ITER_W-1:0]        iter_q;

	logic signed [OFS_W-1:0]  ox, oy;
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic [PROD_W-1:0]        mag_x, mag_y, qx, qy;
	logic                     done_x, done_y;
	logic signed [PROD_W:0]   tx, ty;
	logic signed [WORD_W-1:0] pt_x, pt_y;
	logic signed [64:0]       diff_re, sh_re;
	logic signed [63:0]       sh_im;
	logic signed [WORD_W-1:0] nr, ni;
	logic [64:0]              mag;
	logic [CW-1:0]            k;

	// point mapping
	assign ox     = $signed(OFS_W'(px_q) - CX);
	assign oy     = $signed(OFS_W'(py_q) - CY);
	assign prod_x = PROD_W'(ox) * PROD_W'(scale_q);
	assign prod_y = PROD_W'(oy) * PROD_W'(scale_q);
	assign mag_x  = prod_x[PROD_W-1] ? PROD_W'(-prod_x) : PROD_W'(prod_x);
	assign mag_y  = prod_y[PROD_W-1] ? PROD_W'(-prod_y) : PROD_W'(prod_y);

	etf_div #(.DIVISOR(DX), .WIDTH(PROD_W)) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(mag_x),
		.quotient(qx),
		.done    (done_x)
	);

	etf_div #(.DIVISOR(DY), .WIDTH(PROD_W)) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(mag_y),
		.quotient(qy),
		.done    (done_y)
	);

	assign tx   = negx_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign ty   = negy_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
	assign pt_x = sat32(72'(tx) + 72'(xoff_q));
	assign pt_y = sat32(72'(ty) + 72'(yoff_q));

	// iteration step
	assign diff_re = 65'(rr_s1) - 65'(ii_s1);
	assign sh_re   = diff_re >>> FRAC_BITS;
	assign sh_im   = ri_s1 >>> (FRAC_BITS - 1);
	assign nr      = sat32(72'(sh_re) + 72'(cr_q));
	assign ni      = sat32(72'(sh_im) + 72'(ci_q));
	assign mag     = {1'b0, rr_s1} + {1'b0, ii_s1};
	assign k       = n_q - N_ONE;

	assign st.div_done = done_x && done_y;
	assign st.escape   = (n_q != '0) && (|(mag >> ESC_SHIFT));
	assign st.limit    = n_q == N_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			scale_q <= SCALE_RST;
			xoff_q  <= '0;
			yoff_q  <= '0;
			jre_q   <= JULIA_RE_RST;
			jim_q   <= JULIA_IM_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:         mode_q  <= cfg_wdata[0];
				REG_SCALE:        scale_q <= $signed(cfg_wdata);
				REG_X_OFFSET:     xoff_q  <= $signed(cfg_wdata);
				REG_Y_OFFSET:     yoff_q  <= $signed(cfg_wdata);
				REG_JULIA_C_REAL: jre_q   <= $signed(cfg_wdata);
				REG_JULIA_C_IMAG: jim_q   <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			esc_q <= 1'b0;
		end else begin
			if (cmd.load_z) begin
				n_q <= '0;
			end else if (cmd.step) begin
				n_q <= n_q + N_ONE;
			end
			if (cmd.finish) begin
				esc_q <= st.escape;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (cmd.div_start) begin
			negx_q <= prod_x[PROD_W-1];
			negy_q <= prod_y[PROD_W-1];
		end
		if (cmd.load_z) begin
			if (mode_q) begin
				zr_q <= pt_x;
				zi_q <= pt_y;
				cr_q <= jre_q;
				ci_q <= jim_q;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= pt_x;
				ci_q <= pt_y;
			end
		end else if (cmd.step) begin
			zr_q <= nr;
			zi_q <= ni;
		end
		if (cmd.mul) begin
			rr_s1 <= 64'(zr_q) * 64'(zr_q);
			ii_s1 <= 64'(zi_q) * 64'(zi_q);
			ri_s1 <= 64'(zr_q) * 64'(zi_q);
		end
		if (cmd.out_load) begin
			if (esc_q) begin
				color_q   <= COLOR_W'(k) * COLOR_STEP;
				escaped_q <= 1'b1;
				iter_q    <= ITER_W'(k);
			end else begin
				color_q   <= COLOR_INSIDE;
				escaped_q <= 1'b0;
				iter_q    <= ITER_W'(MAX_ITER);
			end
		end
	end

	assign color      = color_q;
	assign escaped    = escaped_q;
	assign iterations = iter_q;

	a_mandel_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_z && !mode_q |=> (zr_q == '0) && (zi_q == '0))
		else $error("Mandelbrot orbit did not start at zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_MAX)
		else $error("iteration count ran past the limit");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_x == done_y)
		else $error("axis dividers out of step");

endmodule

@@ src/etf_ctrl.sv @@
`timescale 1ns / 1ps

module etf_ctrl
	import etf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  etf_stat_t st,
	output etf_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MAP  = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_OFS  = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_UPD  = 7'b0100000,
		S_DONE = 7'b1000000
	} etf_state_t;

	etf_state_t state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_pix = 1'b1;
					state_d      = S_MAP;
				end
			end
			S_MAP: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_OFS;
				end
			end
			S_OFS: begin
				cmd.load_z = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				if (st.escape || st.limit) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result beat raised outside completion");

	a_accept_maps: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MAP)
		else $error("accepted pixel did not start mapping");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("finished result overwrote a pending beat");

endmodule

@@ src/escape_time_fractal_pixel_top.sv @@
`timescale 1ns / 1ps

// Escape-time fractal pixel engine (Mandelbrot when mode is 0, Julia when 1). Each accepted
// pixel beat is mapped to a Q4.28 point by one multiply and a division by the image
// quarter size, done by reciprocal multiplication on 16-bit digits; then z = z*z + c is
// iterated on three 32x32 multipliers until |z|^2 reaches 4 or MAX_ITER steps are done
// (300 by default). One pixel is in flight at a time; the next is taken while the
// previous result waits in the output register. The user must write the registers
// through cfg_we/cfg_addr/cfg_wdata only while no pixel is in flight; the block itself
// does not enforce it.
module escape_time_fractal_pixel_top
	import etf_pkg::*;
#(
	parameter int MAX_ITER   = MAX_ITER_DEF,
	parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	etf_pixel_if.sink            pix,
	etf_result_if.source         res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [WORD_W-1:0]    cfg_wdata
);

	etf_cmd_t  cmd;
	etf_stat_t st;

	etf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.st       (st),
		.cmd      (cmd)
	);

	etf_dp #(
		.MAX_ITER  (MAX_ITER),
		.IMG_WIDTH (IMG_WIDTH),
		.IMG_HEIGHT(IMG_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pixel_x   (pix.pixel_x),
		.pixel_y   (pix.pixel_y),
		.cmd       (cmd),
		.st        (st),
		.color     (res.color),
		.escaped   (res.escaped),
		.iterations(res.iterations)
	);

endmodule
